>>> hw/rtl/lhbp_pkg.sv
// Shared constants for the local history branch predictor with a learned state map.
package lhbp_pkg;

  localparam int PC_WIDTH     = 64;
  localparam int PERIOD_WIDTH = 16;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd1000;

  localparam int DEF_PC_INDEX_BITS  = 10;
  localparam int DEF_HIST_BITS      = 10;
  localparam int DEF_MAP_INDEX_BITS = 10;
  localparam int DEF_COUNTER_INIT   = 1;
  localparam int DEF_TALLY_BITS     = 16;

  localparam int CTR_WIDTH      = 2;
  localparam int STATES_PER_ROW = 4;
  localparam logic [CTR_WIDTH-1:0] CTR_MAX = 2'd3;
  localparam logic [CTR_WIDTH-1:0] CTR_MIN = 2'd0;

endpackage

>>> hw/rtl/lhbp_ifs.sv
// Handshake channels of the predictor: branch input, prediction output and configuration.
interface lhbp_in_if import lhbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PC_WIDTH-1:0] pc;
  logic                taken;

  modport source (output valid, output pc, output taken, input ready);
  modport sink   (input valid, input pc, input taken, output ready);
endinterface

interface lhbp_out_if import lhbp_pkg::*; ();
  logic valid;
  logic ready;
  logic prediction;
  logic mispredict;
  logic refreshed;

  modport source (output valid, output prediction, output mispredict, output refreshed,
                  input ready);
  modport sink   (input valid, input prediction, input mispredict, input refreshed,
                  output ready);
endinterface

interface lhbp_cfg_if import lhbp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PERIOD_WIDTH-1:0] refresh_period;

  modport source (output valid, output refresh_period, input ready);
  modport sink   (input valid, input refresh_period, output ready);
endinterface

>>> hw/rtl/local_history_branch_predictor_remap.sv
// Local history two-level branch predictor with a periodically rebuilt state-to-prediction map.
//
// in_bus carries one resolved branch per word (pc, taken); out_bus returns one word per
// branch (prediction, mispredict, refreshed) in order. cfg_bus writes refresh_period and
// is always ready; write it only while no branch is in flight.
// A branch's result reaches the output register in steps: the local history is read at its
// accepting edge, then the counter and map row are read, then both are written back as the
// result is loaded. A new branch is accepted only once the last one has loaded its result.
// These accesses use synchronous memories with one read and one write port each, one step per
// cycle while the write-back is not held. Every refresh_period branches the accepting branch
// first triggers a rebuild sweep, one map row read and rewritten per cycle. After reset a
// clearing pass initializes every entry of all three memories; in_bus.ready stays low during
// it. A finished result waits in the output register; the next branch is still accepted and
// only holds in its write-back cycle until the register is free, so a stalled receiver never
// loses or repeats a word.
module local_history_branch_predictor_remap import lhbp_pkg::*; #(
  parameter int PC_INDEX_BITS  = DEF_PC_INDEX_BITS,
  parameter int HIST_BITS      = DEF_HIST_BITS,
  parameter int MAP_INDEX_BITS = DEF_MAP_INDEX_BITS,
  parameter int COUNTER_INIT   = DEF_COUNTER_INIT,
  parameter int TALLY_BITS     = DEF_TALLY_BITS
) (
  input logic       clk,
  input logic       rst_n,
  lhbp_in_if.sink   in_bus,
  lhbp_out_if.source out_bus,
  lhbp_cfg_if.sink  cfg_bus
);

  localparam int HM_BITS   = (HIST_BITS > MAP_INDEX_BITS) ? HIST_BITS : MAP_INDEX_BITS;
  localparam int CLR_BITS  = (PC_INDEX_BITS > HM_BITS) ? PC_INDEX_BITS : HM_BITS;
  localparam int HIST_ENTRIES = 1 << PC_INDEX_BITS;
  localparam int CTR_ENTRIES  = 1 << HIST_BITS;
  localparam int MAP_ROWS     = 1 << MAP_INDEX_BITS;
  localparam int MAP_LSB      = 2 * STATES_PER_ROW * TALLY_BITS;
  localparam int ROW_W        = MAP_LSB + STATES_PER_ROW;
  localparam logic [MAP_INDEX_BITS:0] SWEEP_LAST = (MAP_INDEX_BITS+1)'(MAP_ROWS);
  localparam logic [CTR_WIDTH-1:0] CTR_INIT = CTR_WIDTH'(COUNTER_INIT);
  localparam logic [ROW_W-1:0] ROW_RESET = {4'b1100, {MAP_LSB{1'b0}}};

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_HRD   = 3'd3;
  localparam logic [2:0] ST_CRD   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  // Memories.
  logic [HIST_BITS-1:0] hist_mem [HIST_ENTRIES];
  logic [CTR_WIDTH-1:0] ctr_mem  [CTR_ENTRIES];
  logic [ROW_W-1:0]     row_mem  [MAP_ROWS];
  logic [HIST_BITS-1:0] hist_q;
  logic [CTR_WIDTH-1:0] ctr_q;
  logic [ROW_W-1:0]     row_q;

  // Control and payload registers.
  logic [2:0]                state_r, state_nxt;
  logic [CLR_BITS-1:0]       clr_r, clr_nxt;
  logic [MAP_INDEX_BITS:0]   sw_r, sw_nxt;
  logic [PERIOD_WIDTH-1:0]   period_r, period_nxt;
  logic [PERIOD_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PC_INDEX_BITS-1:0]  pc_idx_r, pc_idx_nxt;
  logic                      tk_r, tk_nxt;
  logic                      refr_r, refr_nxt;
  logic [HIST_BITS-1:0]      cidx_r, cidx_nxt;
  logic                      out_pred_r, out_pred_nxt;
  logic                      out_misp_r, out_misp_nxt;
  logic                      out_refr_r, out_refr_nxt;

  logic                      in_fire;
  logic                      upd_go;
  logic [PERIOD_WIDTH-1:0]   cnt_inc;
  logic                      sweep_now;
  logic [HIST_BITS-1:0]      cidx_sel;
  logic [HM_BITS-1:0]        cidx_ext;
  logic [MAP_INDEX_BITS-1:0] row_of_cidx;
  logic [PC_INDEX_BITS-1:0]  hist_ra;
  logic [MAP_INDEX_BITS-1:0] row_ra;

  logic                      hist_we;
  logic [PC_INDEX_BITS-1:0]  hist_wa;
  logic [HIST_BITS-1:0]      hist_wd;
  logic                      ctr_we;
  logic [HIST_BITS-1:0]      ctr_wa;
  logic [CTR_WIDTH-1:0]      ctr_wd;
  logic                      row_we;
  logic [MAP_INDEX_BITS-1:0] row_wa;
  logic [ROW_W-1:0]          row_wd;

  logic [2:0]                tsel;
  logic [TALLY_BITS-1:0]     tally_old;
  logic [TALLY_BITS-1:0]     tally_new;
  logic                      pred;
  logic [CTR_WIDTH-1:0]      ctr_new;
  logic [ROW_W-1:0]          row_upd;
  logic [ROW_W-1:0]          row_swept;
  logic [TALLY_BITS-1:0]     sw_nt;
  logic [TALLY_BITS-1:0]     sw_tk;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign upd_go        = !out_valid_r || out_bus.ready;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.prediction = out_pred_r;
  assign out_bus.mispredict = out_misp_r;
  assign out_bus.refreshed  = out_refr_r;

  assign cnt_inc   = cnt_r + 1'b1;
  assign sweep_now = (cnt_inc >= period_r);

  // The counter index comes straight from the history memory in the read cycle.
  assign cidx_sel    = (state_r == ST_CRD) ? hist_q : cidx_r;
  assign cidx_ext    = HM_BITS'(cidx_sel);
  assign row_of_cidx = cidx_ext[MAP_INDEX_BITS-1:0];

  assign hist_ra = (state_r == ST_IDLE) ? in_bus.pc[PC_INDEX_BITS-1:0] : pc_idx_r;
  assign row_ra  = (state_r == ST_SWEEP) ? sw_r[MAP_INDEX_BITS-1:0] : row_of_cidx;

  // Branch update: bump one tally, read the map bit, step the counter.
  always_comb begin
    tsel      = {ctr_q, tk_r};
    tally_old = row_q[tsel*TALLY_BITS +: TALLY_BITS];
    tally_new = (tally_old == {TALLY_BITS{1'b1}}) ? tally_old : tally_old + 1'b1;
    pred      = row_q[MAP_LSB + int'(ctr_q)];
    row_upd   = row_q;
    row_upd[tsel*TALLY_BITS +: TALLY_BITS] = tally_new;
    if (tk_r) begin
      ctr_new = (ctr_q == CTR_MAX) ? ctr_q : ctr_q + 1'b1;
    end else begin
      ctr_new = (ctr_q == CTR_MIN) ? ctr_q : ctr_q - 1'b1;
    end
  end

  // Sweep of one row: majority decides each map bit, a tie keeps it, tallies clear.
  always_comb begin
    row_swept = '0;
    sw_nt     = '0;
    sw_tk     = '0;
    for (int s = 0; s < STATES_PER_ROW; s++) begin
      sw_nt = row_q[(2*s)*TALLY_BITS +: TALLY_BITS];
      sw_tk = row_q[(2*s+1)*TALLY_BITS +: TALLY_BITS];
      if (sw_tk > sw_nt) begin
        row_swept[MAP_LSB + s] = 1'b1;
      end else if (sw_tk < sw_nt) begin
        row_swept[MAP_LSB + s] = 1'b0;
      end else begin
        row_swept[MAP_LSB + s] = row_q[MAP_LSB + s];
      end
    end
  end

  // Memory write ports.
  always_comb begin
    hist_we = 1'b0;
    hist_wa = pc_idx_r;
    hist_wd = HIST_BITS'({hist_q, tk_r});
    ctr_we  = 1'b0;
    ctr_wa  = cidx_r;
    ctr_wd  = ctr_new;
    row_we  = 1'b0;
    row_wa  = row_of_cidx;
    row_wd  = row_upd;
    unique case (state_r)
      ST_CLR: begin
        hist_we = 1'b1;
        hist_wa = clr_r[PC_INDEX_BITS-1:0];
        hist_wd = '0;
        ctr_we  = 1'b1;
        ctr_wa  = clr_r[HIST_BITS-1:0];
        ctr_wd  = CTR_INIT;
        row_we  = 1'b1;
        row_wa  = clr_r[MAP_INDEX_BITS-1:0];
        row_wd  = ROW_RESET;
      end
      ST_SWEEP: begin
        // Row sw_r - 1 was read last cycle; write it back while reading the next one.
        row_we = (sw_r != '0);
        row_wa = MAP_INDEX_BITS'(sw_r - 1'b1);
        row_wd = row_swept;
      end
      ST_CRD: begin
        hist_we = 1'b1;
      end
      ST_UPD: begin
        ctr_we = upd_go;
        row_we = upd_go;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hist_q <= hist_mem[hist_ra];
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
  end

  always_ff @(posedge clk) begin
    ctr_q <= ctr_mem[cidx_sel];
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
  end

  always_ff @(posedge clk) begin
    row_q <= row_mem[row_ra];
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    sw_nxt        = sw_r;
    period_nxt    = period_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    pc_idx_nxt    = pc_idx_r;
    tk_nxt        = tk_r;
    refr_nxt      = refr_r;
    cidx_nxt      = cidx_r;
    out_pred_nxt  = out_pred_r;
    out_misp_nxt  = out_misp_r;
    out_refr_nxt  = out_refr_r;

    if (cfg_bus.valid && cfg_bus.ready) begin
      period_nxt = cfg_bus.refresh_period;
    end

    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {CLR_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          pc_idx_nxt = in_bus.pc[PC_INDEX_BITS-1:0];
          tk_nxt     = in_bus.taken;
          refr_nxt   = sweep_now;
          sw_nxt     = '0;
          cnt_nxt    = sweep_now ? '0 : cnt_inc;
          state_nxt  = sweep_now ? ST_SWEEP : ST_CRD;
        end
      end
      ST_SWEEP: begin
        sw_nxt = sw_r + 1'b1;
        if (sw_r == SWEEP_LAST) begin
          state_nxt = ST_HRD;
        end
      end
      ST_HRD: begin
        state_nxt = ST_CRD;
      end
      ST_CRD: begin
        cidx_nxt  = hist_q;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = pred;
          out_misp_nxt  = pred ^ tk_r;
          out_refr_nxt  = refr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      sw_r        <= '0;
      period_r    <= PERIOD_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sw_r        <= sw_nxt;
      period_r    <= period_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_idx_r   <= pc_idx_nxt;
    tk_r       <= tk_nxt;
    refr_r     <= refr_nxt;
    cidx_r     <= cidx_nxt;
    out_pred_r <= out_pred_nxt;
    out_misp_r <= out_misp_nxt;
    out_refr_r <= out_refr_nxt;
  end

  // A branch that reaches the period starts a sweep and restarts the count.
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sweep_now) |=> (state_r == ST_SWEEP && cnt_r == '0 && sw_r == '0))
    else $error("sweep did not start after period reached");

  // The last sweep row is followed by the history re-read.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sw_r == SWEEP_LAST) |=> (state_r == ST_HRD))
    else $error("sweep did not hand over to the branch");

  // A write-back stalled on a full output register must not touch the tables.
  a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && !upd_go) |-> (!row_we && !ctr_we))
    else $error("table written while result could not be stored");

  // A result loaded while the old one is still waiting would overwrite it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(out_pred_r)
                                         && $stable(out_refr_r)))
    else $error("pending result overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the local history branch predictor with its rebuilt state map.
module tb_top import lhbp_pkg::*; ();

  localparam int PC_IDX_W     = DEF_PC_INDEX_BITS;
  localparam int HIST_W       = DEF_HIST_BITS;
  localparam int MAP_IDX_W    = DEF_MAP_INDEX_BITS;
  localparam int TALLY_W      = DEF_TALLY_BITS;
  localparam int HIST_ROWS    = 1 << PC_IDX_W;
  localparam int CTR_ROWS     = 1 << HIST_W;
  localparam int MAP_ROWS     = 1 << MAP_IDX_W;
  localparam logic [TALLY_W-1:0] TALLY_TOP = '1;
  localparam int SITES        = 8;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE       = 16;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PC_WIDTH-1:0] pc;
    logic                taken;
  } branch_t;

  typedef struct packed {
    logic prediction;
    logic mispredict;
    logic refreshed;
  } verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lhbp_in_if  in_bus ();
  lhbp_out_if out_bus ();
  lhbp_cfg_if cfg_bus ();

  local_history_branch_predictor_remap u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the predictor state.
  logic [HIST_W-1:0]       hist_tbl    [HIST_ROWS];
  logic [CTR_WIDTH-1:0]    ctr_tbl     [CTR_ROWS];
  logic [TALLY_W-1:0]      taken_tally [MAP_ROWS][STATES_PER_ROW];
  logic [TALLY_W-1:0]      fall_tally  [MAP_ROWS][STATES_PER_ROW];
  logic                    dir_map     [MAP_ROWS][STATES_PER_ROW];
  logic [PERIOD_WIDTH-1:0] period_now;
  logic [PERIOD_WIDTH-1:0] branches_since;

  branch_t  branch_q [$];
  verdict_t verdict_q [$];

  bit fire_in, fire_out, fire_cfg;
  int unsigned queued_cnt, accepted_cnt, checked_cnt, mispredict_cnt;
  int unsigned rebuild_cnt, period_writes, fail_cnt, quiet_cycles;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_request, hold_left;

  logic [PC_WIDTH-1:0] site_pc  [SITES];
  logic [15:0]         site_pat [SITES];
  int unsigned         site_len [SITES];
  int unsigned         site_pos [SITES];

  function automatic void clear_predictor();
    for (int i = 0; i < HIST_ROWS; i++) hist_tbl[i] = '0;
    for (int i = 0; i < CTR_ROWS; i++) ctr_tbl[i] = CTR_WIDTH'(DEF_COUNTER_INIT);
    for (int r = 0; r < MAP_ROWS; r++) begin
      for (int s = 0; s < STATES_PER_ROW; s++) begin
        taken_tally[r][s] = '0;
        fall_tally[r][s]  = '0;
        dir_map[r][s]     = (s >= 2);
      end
    end
    period_now     = PERIOD_RESET;
    branches_since = '0;
  endfunction

  // Majority vote per row and state; a tie leaves the direction alone.
  function automatic void rebuild_map();
    for (int r = 0; r < MAP_ROWS; r++) begin
      for (int s = 0; s < STATES_PER_ROW; s++) begin
        if (taken_tally[r][s] > fall_tally[r][s]) dir_map[r][s] = 1'b1;
        else if (taken_tally[r][s] < fall_tally[r][s]) dir_map[r][s] = 1'b0;
        taken_tally[r][s] = '0;
        fall_tally[r][s]  = '0;
      end
    end
  endfunction

  function automatic verdict_t predict_branch(branch_t br);
    int unsigned          slot, cidx, row;
    logic [CTR_WIDTH-1:0] st;
    verdict_t             v;
    v = '0;
    branches_since = branches_since + 1'b1;
    if (branches_since >= period_now) begin
      branches_since = '0;
      rebuild_map();
      v.refreshed = 1'b1;
      rebuild_cnt++;
    end
    slot = br.pc[PC_IDX_W-1:0];
    cidx = hist_tbl[slot];
    row  = cidx % MAP_ROWS;
    st   = ctr_tbl[cidx];
    if (br.taken) begin
      if (taken_tally[row][st] != TALLY_TOP) taken_tally[row][st] = taken_tally[row][st] + 1'b1;
    end else if (fall_tally[row][st] != TALLY_TOP) begin
      fall_tally[row][st] = fall_tally[row][st] + 1'b1;
    end
    v.prediction = dir_map[row][st];
    v.mispredict = v.prediction ^ br.taken;
    if (br.taken && st != CTR_MAX) ctr_tbl[cidx] = st + 1'b1;
    else if (!br.taken && st != CTR_MIN) ctr_tbl[cidx] = st - 1'b1;
    hist_tbl[slot] = HIST_W'((cidx << 1) | br.taken);
    return v;
  endfunction

  // Every odd site shares its history slot with the site before it.
  function automatic void reseed_sites();
    for (int k = 0; k < SITES; k++) begin
      site_pc[k]  = {$urandom, $urandom};
      site_len[k] = $urandom_range(12, 1);
      site_pos[k] = 0;
      if ($urandom_range(1)) site_pat[k] = ~(16'd1 << (site_len[k] - 1));
      else site_pat[k] = 16'($urandom);
      if (k % 2 == 1) site_pc[k][PC_IDX_W-1:0] = site_pc[k-1][PC_IDX_W-1:0];
    end
  endfunction

  // Mostly repeating per-site outcome patterns, with some random and flipped branches.
  function automatic branch_t make_branch();
    branch_t     br;
    int unsigned k;
    k = $urandom_range(SITES - 1);
    br.pc    = site_pc[k];
    br.taken = site_pat[k][site_pos[k]];
    site_pos[k] = (site_pos[k] + 1) % site_len[k];
    case ($urandom_range(9))
      0, 1: begin
        br.pc    = {$urandom, $urandom};
        br.taken = $urandom_range(1);
      end
      2: br.taken = ~br.taken;
      default: ;
    endcase
    return br;
  endfunction

  function automatic void queue_branch(logic [PC_WIDTH-1:0] pc, logic taken);
    branch_t br;
    br.pc    = pc;
    br.taken = taken;
    branch_q.push_back(br);
    queued_cnt++;
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 45; recv_idle_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 45; end
      IDLE_BOTH: begin send_idle_pct = 15; recv_idle_pct = 15; end
      default:   begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endfunction

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || verdict_q.size() != 0) @(negedge clk);
  endtask

  // Wait until every branch has been answered, so none is in flight, and let the block settle.
  task automatic write_period(input logic [PERIOD_WIDTH-1:0] value);
    wait_idle();
    repeat (SETTLE) @(negedge clk);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.refresh_period <= value;
    do @(negedge clk); while (!fire_cfg);
    cfg_bus.valid <= 1'b0;
    period_writes++;
  endtask

  task automatic run_random(input logic [PERIOD_WIDTH-1:0] period, input int count,
                            input idle_mode_t mode, input bit squeeze);
    int i;
    write_period(period);
    set_idle(mode);
    reseed_sites();
    if (squeeze) hold_request = 1;
    for (i = 0; i < count; i++) begin
      branch_q.push_back(make_branch());
      queued_cnt++;
    end
  endtask

  always @(negedge clk) begin : branch_driver
    branch_t br;
    if (rst_n && (!in_bus.valid || fire_in)) begin
      if (branch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        br = branch_q.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.pc    <= br.pc;
        in_bus.taken <= br.taken;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    if (hold_request != 0) begin
      hold_left    = LONG_HOLD;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    branch_t  br;
    fire_in  = rst_n && in_bus.valid && in_bus.ready;
    fire_out = rst_n && out_bus.valid && out_bus.ready;
    fire_cfg = rst_n && cfg_bus.valid && cfg_bus.ready;
    if (fire_out) begin
      if (verdict_q.size() == 0) begin
        $error("prediction word with no branch outstanding");
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        checked_cnt++;
        if (out_bus.prediction !== want.prediction) begin
          $error("prediction: expected %0b, got %0b", want.prediction, out_bus.prediction);
          fail_cnt++;
        end
        if (out_bus.mispredict !== want.mispredict) begin
          $error("mispredict: expected %0b, got %0b", want.mispredict, out_bus.mispredict);
          fail_cnt++;
        end
        if (out_bus.refreshed !== want.refreshed) begin
          $error("refreshed: expected %0b, got %0b", want.refreshed, out_bus.refreshed);
          fail_cnt++;
        end
        if (want.mispredict) mispredict_cnt++;
      end
    end
    if (fire_cfg) period_now = cfg_bus.refresh_period;
    if (fire_in) begin
      br.pc    = in_bus.pc;
      br.taken = in_bus.taken;
      verdict_q.push_back(predict_branch(br));
      accepted_cnt++;
    end
    if (fire_in || fire_out || fire_cfg) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles, %0d predictions outstanding",
               STALL_LIMIT, verdict_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_bus.valid           = 1'b0;
    in_bus.pc              = '0;
    in_bus.taken           = 1'b0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.refresh_period = PERIOD_RESET;
    clear_predictor();
    set_idle(IDLE_NONE);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Address extremes, then one slot driven through both counter limits under aliased pcs.
    queue_branch('0, 1'b0);
    queue_branch('1, 1'b1);
    queue_branch(64'h8000_0000_0000_0000, 1'b1);
    queue_branch(64'h0000_0000_0000_03ff, 1'b0);
    for (int i = 0; i < 13; i++)
      queue_branch((i % 2) ? 64'haaaa_5555_0000_0155 : 64'h5555_aaaa_ffff_fd55, 1'b1);
    queue_branch(64'h0123_4567_89ab_c155, 1'b0);
    queue_branch(64'hfedc_ba98_7654_3155, 1'b0);

    // A period of zero behaves like one: every branch rebuilds the map first.
    write_period('0);
    queue_branch(64'h0000_0000_0000_0155, 1'b1);
    queue_branch(64'h0000_0000_0000_0155, 1'b0);
    queue_branch(64'hffff_ffff_ffff_fc00, 1'b1);
    write_period(16'd1);
    queue_branch(64'h0000_0000_0000_0001, 1'b0);
    queue_branch(64'h0000_0000_0000_0001, 1'b1);
    queue_branch(64'h7fff_ffff_ffff_ffff, 1'b0);

    // The long receiver hold-off rides on the first phase; the next phase lowers the
    // period below the running count.
    run_random(16'hffff, 300, IDLE_NONE, 1'b1);
    run_random(16'd4,    200, IDLE_SEND, 1'b0);
    run_random(16'd37,   350, IDLE_RECV, 1'b0);
    run_random(16'd150,  350, IDLE_BOTH, 1'b0);
    run_random(16'd12,   300, IDLE_SEND, 1'b0);
    run_random(16'd1,     20, IDLE_RECV, 1'b0);
    run_random(16'd300,  330, IDLE_NONE, 1'b0);

    wait_idle();
    repeat (SETTLE) @(negedge clk);
    $display("Checked %0d predictions (%0d mispredicts) across %0d map rebuilds.",
             checked_cnt, mispredict_cnt, rebuild_cnt);
    $display("Refresh period written %0d times, including 0, 1 and 65535, under all stall mixes.",
             period_writes);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
